FILE: rtl/dss_pkg.sv
// Shared types and constants for the decode slot scheduler.
// Used by dss_ctrl, dss_datapath and decode_slot_scheduler_unit; depends on nothing.
package dss_pkg;

    localparam int MAX_SLOTS_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 64;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_SLOTS_W = 5;
    localparam int SLOTS_RST   = 16;

    localparam logic [15:0] CTX_RST  = 16'd4096;
    localparam logic        STOP_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd2;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_TOKEN  = 1'b1;

    localparam logic [17:0] END_TOKEN_A = 18'd151645;
    localparam logic [17:0] END_TOKEN_B = 18'd151643;

    localparam logic [2:0] EV_ADMITTED  = 3'd0;
    localparam logic [2:0] EV_QUEUED    = 3'd1;
    localparam logic [2:0] EV_CONTINUES = 3'd2;
    localparam logic [2:0] EV_FINISHED  = 3'd3;
    localparam logic [2:0] EV_REJECTED  = 3'd4;
    localparam logic [2:0] EV_IDLE_SLOT = 3'd5;

    typedef struct packed {
        logic load;
        logic read;
        logic admit;
        logic from_fifo;
        logic last;
        logic queue;
        logic token;
    } t_dss_cmd;

    typedef struct packed {
        logic is_token;
        logic fc_zero;
        logic wc_zero;
        logic slot_ok;
        logic tok_done;
        logic out_free;
    } t_dss_sts;

endpackage

FILE: rtl/dss_ctrl.sv
// Sequencer of the decode slot scheduler: steps one input word through
// read, admit, queue and token phases. Depends on dss_pkg.
module dss_ctrl import dss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dss_sts i_sts,
    output t_dss_cmd o_cmd,
    output logic     o_in_stall
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_ISSUE   = 8'b0000_0010,
        ST_ADM_NEW = 8'b0000_0100,
        ST_ADM_PRE = 8'b0000_1000,
        ST_QUEUE   = 8'b0001_0000,
        ST_TOKEN   = 8'b0010_0000,
        ST_FETCH   = 8'b0100_0000,
        ST_ADM_TOK = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.read = 1'b1;
                if (i_sts.is_token) begin
                    n_state = ST_TOKEN;
                end else if (i_sts.fc_zero) begin
                    n_state = ST_QUEUE;
                end else if (i_sts.wc_zero) begin
                    n_state = ST_ADM_NEW;
                end else begin
                    n_state = ST_ADM_PRE;
                end
            end
            ST_ADM_NEW: begin
                if (i_sts.out_free) begin
                    o_cmd.admit = 1'b1;
                    o_cmd.last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_ADM_PRE: begin
                if (i_sts.out_free) begin
                    o_cmd.admit     = 1'b1;
                    o_cmd.from_fifo = 1'b1;
                    n_state         = ST_QUEUE;
                end
            end
            ST_QUEUE: begin
                if (i_sts.out_free) begin
                    o_cmd.queue = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_TOKEN: begin
                if (i_sts.out_free) begin
                    o_cmd.token = 1'b1;
                    if (i_sts.slot_ok && i_sts.tok_done && !i_sts.wc_zero) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.read = 1'b1;
                n_state    = ST_ADM_TOK;
            end
            ST_ADM_TOK: begin
                if (i_sts.out_free) begin
                    o_cmd.admit     = 1'b1;
                    o_cmd.from_fifo = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/dss_datapath.sv
// Datapath of the decode slot scheduler: free-slot stack, wait FIFO, slot records,
// configuration registers and the output word register. Depends on dss_pkg.
module dss_datapath import dss_pkg::*; #(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dss_cmd              i_cmd,
    output t_dss_sts              o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_opcode,
    input  logic [15:0]           i_request_tag,
    input  logic [15:0]           i_token_budget,
    input  logic [15:0]           i_prompt_length,
    input  logic [3:0]            i_slot_id,
    input  logic [17:0]           i_token_value,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [2:0]            o_event_kind,
    output logic [3:0]            o_slot_number,
    output logic [15:0]           o_tag_out,
    output logic [15:0]           o_clamped_prompt,
    output logic [15:0]           o_tokens_emitted,
    output logic                  o_last_of_run
);

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int WW = $clog2(WAIT_DEPTH);
    localparam int QW = $clog2(WAIT_DEPTH + 1);
    localparam int NW = (CW > CFG_SLOTS_W) ? CW : CFG_SLOTS_W;
    localparam int RST_SLOTS = (MAX_SLOTS < SLOTS_RST) ? MAX_SLOTS : SLOTS_RST;

    logic        r_op;
    logic [15:0] r_tag, r_budget, r_prompt;
    logic [3:0]  r_slot;
    logic [17:0] r_token;

    logic [CW-1:0] r_nslots;
    logic [15:0]   r_ctx;
    logic          r_stop;

    logic [CW-1:0]        r_fc;
    logic [WW-1:0]        r_head;
    logic [QW-1:0]        r_wc;
    logic [MAX_SLOTS-1:0] r_active;
    logic [MAX_SLOTS-1:0] r_stk_vld;

    logic [SW-1:0] r_stk_mem [MAX_SLOTS];
    logic [63:0]   r_rec_mem [MAX_SLOTS];
    logic [47:0]   r_wq_mem  [WAIT_DEPTH];

    logic [SW-1:0] r_stk_rd;
    logic [SW-1:0] r_stk_idx;
    logic [63:0]   r_rec_rd;
    logic [47:0]   r_wq_rd;

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [3:0]  r_oslot;
    logic [15:0] r_otag, r_oclamp, r_oemit;
    logic        r_olast;

    logic [2:0]  n_kind;
    logic [3:0]  n_oslot;
    logic [15:0] n_otag, n_oclamp, n_oemit;
    logic        n_olast;

    logic [SW-1:0] slot_ix;
    logic          slot_ok;
    logic [15:0]   rec_tag, rec_budget, rec_em, rec_pos;
    logic [15:0]   em_inc, pos_inc;
    logic          is_end, tok_done;
    logic [SW-1:0] stk_top;
    logic [15:0]   a_tag, a_budget, a_prompt, a_clamp;
    logic [QW:0]   tail_sum;
    logic [WW-1:0] tail, head_nx;
    logic          wq_full, fc_full, out_free, emit;
    logic [NW-1:0] cfg_n_wide;
    logic [CW-1:0] cfg_n;
    logic          tok_fin;

    assign slot_ix    = SW'(r_slot);
    assign slot_ok    = (32'(r_slot) < 32'(MAX_SLOTS)) && r_active[slot_ix];
    assign rec_tag    = r_rec_rd[63:48];
    assign rec_budget = r_rec_rd[47:32];
    assign rec_em     = r_rec_rd[31:16];
    assign rec_pos    = r_rec_rd[15:0];
    assign em_inc     = (rec_em != 16'hFFFF) ? rec_em + 16'd1 : rec_em;
    assign pos_inc    = (rec_em != 16'd0 && rec_pos != 16'hFFFF) ? rec_pos + 16'd1 : rec_pos;
    assign is_end     = r_stop && (r_token == END_TOKEN_A || r_token == END_TOKEN_B);
    assign tok_done   = (em_inc >= rec_budget) || is_end || (pos_inc >= r_ctx);
    assign tok_fin    = i_cmd.token && slot_ok && tok_done;

    assign stk_top = r_stk_vld[r_stk_idx] ? r_stk_rd
                   : SW'(r_nslots - CW'(1) - CW'(r_stk_idx));

    assign a_tag    = i_cmd.from_fifo ? r_wq_rd[47:32] : r_tag;
    assign a_budget = i_cmd.from_fifo ? r_wq_rd[31:16] : r_budget;
    assign a_prompt = i_cmd.from_fifo ? r_wq_rd[15:0]  : r_prompt;
    assign a_clamp  = (a_prompt > r_ctx) ? r_ctx : a_prompt;

    assign tail_sum = (QW+1)'(r_head) + (QW+1)'(r_wc);
    assign tail     = (tail_sum >= (QW+1)'(WAIT_DEPTH)) ? WW'(tail_sum - (QW+1)'(WAIT_DEPTH))
                                                        : WW'(tail_sum);
    assign head_nx  = (r_head == WW'(WAIT_DEPTH - 1)) ? '0 : r_head + WW'(1);
    assign wq_full  = (r_wc == QW'(WAIT_DEPTH));
    assign fc_full  = (r_fc == CW'(MAX_SLOTS));

    assign cfg_n_wide = (NW'(i_cfg_data[CFG_SLOTS_W-1:0]) > NW'(MAX_SLOTS))
                      ? NW'(MAX_SLOTS) : NW'(i_cfg_data[CFG_SLOTS_W-1:0]);
    assign cfg_n      = CW'(cfg_n_wide);

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = i_cmd.admit || i_cmd.queue || i_cmd.token;

    assign o_sts.is_token = (r_op == OP_TOKEN);
    assign o_sts.fc_zero  = (r_fc == '0);
    assign o_sts.wc_zero  = (r_wc == '0);
    assign o_sts.slot_ok  = slot_ok;
    assign o_sts.tok_done = tok_done;
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_tag    <= i_request_tag;
            r_budget <= i_token_budget;
            r_prompt <= i_prompt_length;
            r_slot   <= i_slot_id;
            r_token  <= i_token_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_stk_idx <= SW'(r_fc - CW'(1));
            r_stk_rd  <= r_stk_mem[SW'(r_fc - CW'(1))];
            r_wq_rd   <= r_wq_mem[r_head];
            r_rec_rd  <= r_rec_mem[slot_ix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_fin && !fc_full) begin
            r_stk_mem[SW'(r_fc)] <= slot_ix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.admit) begin
            r_rec_mem[stk_top] <= {a_tag, a_budget, 16'd0, a_clamp};
        end else if (i_cmd.token && slot_ok) begin
            r_rec_mem[slot_ix] <= {rec_tag, rec_budget, em_inc, pos_inc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.queue && !wq_full) begin
            r_wq_mem[tail] <= {r_tag, r_budget, r_prompt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nslots    <= CW'(RST_SLOTS);
            r_ctx       <= CTX_RST;
            r_stop      <= STOP_RST;
            r_fc        <= CW'(RST_SLOTS);
            r_head      <= '0;
            r_wc        <= '0;
            r_active    <= '0;
            r_stk_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS: begin
                        r_nslots  <= cfg_n;
                        r_fc      <= cfg_n;
                        r_active  <= '0;
                        r_stk_vld <= '0;
                    end
                    CFG_CTX: begin
                        r_ctx <= i_cfg_data;
                    end
                    CFG_STOP: begin
                        r_stop <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.admit) begin
                r_fc              <= r_fc - CW'(1);
                r_active[stk_top] <= 1'b1;
                if (i_cmd.from_fifo) begin
                    r_head <= head_nx;
                    r_wc   <= r_wc - QW'(1);
                end
            end
            if (i_cmd.queue && !wq_full) begin
                r_wc <= r_wc + QW'(1);
            end
            if (tok_fin) begin
                r_active[slot_ix] <= 1'b0;
                if (!fc_full) begin
                    r_fc                 <= r_fc + CW'(1);
                    r_stk_vld[SW'(r_fc)] <= 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_kind   = EV_ADMITTED;
        n_oslot  = 4'd0;
        n_otag   = 16'd0;
        n_oclamp = 16'd0;
        n_oemit  = 16'd0;
        n_olast  = 1'b1;
        if (i_cmd.admit) begin
            n_oslot  = 4'(stk_top);
            n_otag   = a_tag;
            n_oclamp = a_clamp;
            n_olast  = i_cmd.last;
        end else if (i_cmd.queue) begin
            n_kind = wq_full ? EV_REJECTED : EV_QUEUED;
            n_otag = r_tag;
        end else if (i_cmd.token) begin
            n_oslot = r_slot;
            if (!slot_ok) begin
                n_kind = EV_IDLE_SLOT;
            end else begin
                n_kind  = tok_done ? EV_FINISHED : EV_CONTINUES;
                n_otag  = rec_tag;
                n_oemit = em_inc;
                n_olast = !(tok_done && r_wc != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= n_kind;
            r_oslot  <= n_oslot;
            r_otag   <= n_otag;
            r_oclamp <= n_oclamp;
            r_oemit  <= n_oemit;
            r_olast  <= n_olast;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_kind;
    assign o_slot_number    = r_oslot;
    assign o_tag_out        = r_otag;
    assign o_clamped_prompt = r_oclamp;
    assign o_tokens_emitted = r_oemit;
    assign o_last_of_run    = r_olast;

endmodule

FILE: rtl/decode_slot_scheduler_unit.sv
// Decode slot scheduler: hands sequence slots to submitted requests, queues the
// rest and retires slots as token words arrive.
// Top level; depends on dss_pkg, dss_ctrl and dss_datapath.
//
// Input channel: i_in_valid / o_in_stall carry one word (opcode 0 submit, 1 token).
// Output channel: o_out_valid / i_out_stall carry event words; one or two per
// input word, the final one flagged by o_last_of_run.
// Configuration: i_cfg_we writes register i_cfg_index (0 slot count, 1 context
// limit, 2 end-token stop) at a clock edge; the user must write only while no
// word is in flight, as the block does not enforce this.
// Timing: one output register; an accepted word is loaded, then the stack, FIFO
// and slot record memories are read into registers, then the first result is
// written. A submit admitting a waiting request then writes its queue result; a
// finishing token admitting one reads the FIFO again before its admit result.
// A stalled output holds its word; the sequencer waits before writing the next
// result, and the input stays stalled until the word's last result is written.
// Reset (synchronous, active low): all slots idle and free, queue empty, slot
// count 16 (clipped to MAX_SLOTS), context limit 4096, end-token stop on.
module decode_slot_scheduler_unit import dss_pkg::*; #(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [15:0]           i_request_tag,
    input  logic [15:0]           i_token_budget,
    input  logic [15:0]           i_prompt_length,
    input  logic [3:0]            i_slot_id,
    input  logic [17:0]           i_token_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_event_kind,
    output logic [3:0]            o_slot_number,
    output logic [15:0]           o_tag_out,
    output logic [15:0]           o_clamped_prompt,
    output logic [15:0]           o_tokens_emitted,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dss_cmd cmd;
    t_dss_sts sts;

    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dss_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_request_tag    (i_request_tag),
        .i_token_budget   (i_token_budget),
        .i_prompt_length  (i_prompt_length),
        .i_slot_id        (i_slot_id),
        .i_token_value    (i_token_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_event_kind     (o_event_kind),
        .o_slot_number    (o_slot_number),
        .o_tag_out        (o_tag_out),
        .o_clamped_prompt (o_clamped_prompt),
        .o_tokens_emitted (o_tokens_emitted),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
